// File: rtl/core/ldsg_pkg.sv
// Shared types, constants and codes for the light disc stamp grid.
package ldsg_pkg;

    localparam int DEF_GRID_WIDTH  = 128;
    localparam int DEF_GRID_HEIGHT = 128;
    localparam int DEF_HARD_RADIUS = 3;
    localparam int DEF_SOFT_RADIUS = 14;

    localparam int COLOUR_W    = 32;
    localparam int COORD_W     = 12;
    localparam int CELL_IDX_W  = 7;
    localparam int POS_W       = 15;
    localparam int ADDR_MAX_W  = 16;
    localparam int ADDR_CALC_W = 17;
    localparam int QUEUE_DEPTH = 2;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = 3;

    localparam logic [COLOUR_W-1:0] WHITE_COLOUR = 32'hFFFF_FFFF;
    localparam logic [COLOUR_W-1:0] HARD_COLOUR  = 32'hFFC0_D0D0;
    localparam logic [COLOUR_W-1:0] SOFT_COLOUR  = 32'hFF80_9090;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_STAMP = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_AMBIENT_RED   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AMBIENT_GREEN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AMBIENT_BLUE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_AMBIENT_ALPHA = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DAYTIME       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CAMERA_X      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CAMERA_Z      = 3'd6;

    typedef enum logic [1:0] {
        OP_FILL,
        OP_STAMP,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FILL,
        BK_STAMP,
        BK_READ,
        BK_READ_WAIT
    } back_state_t;

    typedef struct packed {
        logic [7:0]         ambient_red;
        logic [7:0]         ambient_green;
        logic [7:0]         ambient_blue;
        logic [7:0]         ambient_alpha;
        logic               daytime;
        logic [COORD_W-1:0] camera_x;
        logic [COORD_W-1:0] camera_z;
    } cfg_t;

    typedef struct packed {
        op_t                     op;
        logic [COLOUR_W-1:0]     colour;
        logic signed [POS_W-1:0] col_base;
        logic signed [POS_W-1:0] row_base;
        logic [ADDR_MAX_W-1:0]   addr;
        logic                    in_grid;
    } entry_t;

    typedef struct packed {
        logic full;
        logic init_busy;
    } front_status_t;

endpackage

// File: rtl/core/light_disc_stamp_grid.sv
// Top level of the light disc stamp grid: configuration registers and unit wiring.
//
// After reset the block runs a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells
// that paints every cell opaque white, holding item_stall high; configuration
// writes are taken throughout. Items then enter a two-entry queue and are
// carried out one at a time by the back end around its cell memory, which has
// one read port and one write port: a clear sweeps every cell, a night stamp
// visits (2*SOFT_RADIUS+1)^2 cells with a read-modify-write, and a read returns
// one cell or, outside the grid, the ambient colour. Daytime stamps and unused
// commands are dropped at the front without a result.
module light_disc_stamp_grid
    import ldsg_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    parameter int HARD_RADIUS = DEF_HARD_RADIUS,
    parameter int SOFT_RADIUS = DEF_SOFT_RADIUS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [1:0]            command,
    input  logic [COORD_W-1:0]    light_x,
    input  logic [COORD_W-1:0]    light_z,
    input  logic [CELL_IDX_W-1:0] cell_column,
    input  logic [CELL_IDX_W-1:0] cell_row,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic [7:0]            alpha
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    front_status_t        status;
    logic                 push;
    entry_t               push_data;
    logic                 q_full;
    logic                 q_valid;
    entry_t               q_head;
    logic                 pop;
    logic                 init_busy;
    logic [COLOUR_W-1:0]  result_colour;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign reg_idx   = paddr[PADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                REG_AMBIENT_RED:   cfg_next.ambient_red   = pwdata[7:0];
                REG_AMBIENT_GREEN: cfg_next.ambient_green = pwdata[7:0];
                REG_AMBIENT_BLUE:  cfg_next.ambient_blue  = pwdata[7:0];
                REG_AMBIENT_ALPHA: cfg_next.ambient_alpha = pwdata[7:0];
                REG_DAYTIME:       cfg_next.daytime       = pwdata[0];
                REG_CAMERA_X:      cfg_next.camera_x      = pwdata[COORD_W-1:0];
                REG_CAMERA_Z:      cfg_next.camera_z      = pwdata[COORD_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_AMBIENT_RED:   prdata = PDATA_W'(cfg_reg.ambient_red);
            REG_AMBIENT_GREEN: prdata = PDATA_W'(cfg_reg.ambient_green);
            REG_AMBIENT_BLUE:  prdata = PDATA_W'(cfg_reg.ambient_blue);
            REG_AMBIENT_ALPHA: prdata = PDATA_W'(cfg_reg.ambient_alpha);
            REG_DAYTIME:       prdata = PDATA_W'(cfg_reg.daytime);
            REG_CAMERA_X:      prdata = PDATA_W'(cfg_reg.camera_x);
            REG_CAMERA_Z:      prdata = PDATA_W'(cfg_reg.camera_z);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ambient_red   <= 8'hFF;
            cfg_reg.ambient_green <= 8'hFF;
            cfg_reg.ambient_blue  <= 8'hFF;
            cfg_reg.ambient_alpha <= 8'hFF;
            cfg_reg.daytime       <= 1'b1;
            cfg_reg.camera_x      <= '0;
            cfg_reg.camera_z      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign status.full      = q_full;
    assign status.init_busy = init_busy;

    ldsg_front #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .SOFT_RADIUS (SOFT_RADIUS)
    ) u_front (
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .command     (command),
        .light_x     (light_x),
        .light_z     (light_z),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .cfg         (cfg_reg),
        .status      (status),
        .push        (push),
        .push_data   (push_data)
    );

    ldsg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    ldsg_back #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .HARD_RADIUS (HARD_RADIUS),
        .SOFT_RADIUS (SOFT_RADIUS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .pop           (pop),
        .init_busy     (init_busy),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_colour (result_colour)
    );

    assign red   = result_colour[7:0];
    assign green = result_colour[15:8];
    assign blue  = result_colour[23:16];
    assign alpha = result_colour[31:24];

endmodule

// File: rtl/core/ldsg_front.sv
// Front end: accepts input beats, classifies them and builds queue entries.
module ldsg_front
    import ldsg_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    parameter int SOFT_RADIUS = DEF_SOFT_RADIUS
) (
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [1:0]            command,
    input  logic [COORD_W-1:0]    light_x,
    input  logic [COORD_W-1:0]    light_z,
    input  logic [CELL_IDX_W-1:0] cell_column,
    input  logic [CELL_IDX_W-1:0] cell_row,
    input  cfg_t                  cfg,
    input  front_status_t         status,
    output logic                  push,
    output entry_t                push_data
);

    logic                    accept;
    logic                    keep;
    logic [COLOUR_W-1:0]     ambient;
    logic [ADDR_CALC_W-1:0]  rd_lin;
    logic                    rd_in_grid;
    logic signed [POS_W-1:0] col_base;
    logic signed [POS_W-1:0] row_base;

    assign item_stall = status.full | status.init_busy;
    assign accept     = item_valid & ~item_stall;
    assign ambient    = {cfg.ambient_alpha, cfg.ambient_blue, cfg.ambient_green,
                         cfg.ambient_red};

    always_comb
    begin
        rd_lin = ADDR_CALC_W'(cell_column) * ADDR_CALC_W'(GRID_HEIGHT)
               + ADDR_CALC_W'(cell_row);
        rd_in_grid = (ADDR_CALC_W'(cell_column) < ADDR_CALC_W'(GRID_WIDTH))
                   && (ADDR_CALC_W'(cell_row) < ADDR_CALC_W'(GRID_HEIGHT));
        col_base = $signed(POS_W'(GRID_WIDTH / 2))
                 + $signed({3'b000, light_x})
                 - $signed({3'b000, cfg.camera_x})
                 - $signed(POS_W'(SOFT_RADIUS));
        row_base = $signed(POS_W'(GRID_HEIGHT / 2))
                 + $signed({3'b000, light_z})
                 - $signed({3'b000, cfg.camera_z})
                 - $signed(POS_W'(SOFT_RADIUS));
    end

    always_comb
    begin
        keep               = 1'b0;
        push_data.op       = OP_FILL;
        push_data.colour   = ambient;
        push_data.col_base = col_base;
        push_data.row_base = row_base;
        push_data.addr     = rd_lin[ADDR_MAX_W-1:0];
        push_data.in_grid  = rd_in_grid;
        case (command)
            CMD_CLEAR:
            begin
                keep         = 1'b1;
                push_data.op = OP_FILL;
            end
            CMD_STAMP:
            begin
                keep         = ~cfg.daytime;
                push_data.op = OP_STAMP;
            end
            CMD_READ:
            begin
                keep         = 1'b1;
                push_data.op = OP_READ;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept & keep;

endmodule

// File: rtl/core/ldsg_queue.sv
// Short entry queue between the front end and the back end.
module ldsg_queue
    import ldsg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   valid,
    output entry_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");

endmodule

// File: rtl/core/ldsg_back.sv
// Back end: cell memory, fill sweep, stamp read-modify-write and cell reads.
module ldsg_back
    import ldsg_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    parameter int HARD_RADIUS = DEF_HARD_RADIUS,
    parameter int SOFT_RADIUS = DEF_SOFT_RADIUS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  entry_t              q_head,
    output logic                pop,
    output logic                init_busy,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [COLOUR_W-1:0] result_colour
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_WIDTH);
    localparam int RW    = $clog2(GRID_HEIGHT);
    localparam int CNT_W = $clog2(2 * SOFT_RADIUS + 1);
    localparam int D_W   = CNT_W + 1;
    localparam int SQ_W  = 2 * D_W + 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(2 * SOFT_RADIUS);
    localparam logic [SQ_W-1:0]  HARD_SQ   = SQ_W'(HARD_RADIUS * HARD_RADIUS);
    localparam logic [SQ_W-1:0]  SOFT_SQ   = SQ_W'(SOFT_RADIUS * SOFT_RADIUS);

    logic [COLOUR_W-1:0] mem [CELLS];
    logic [COLOUR_W-1:0] rd_data_reg;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [AW-1:0]       fill_addr_reg;
    logic [AW-1:0]       fill_addr_next;
    logic [COLOUR_W-1:0] fill_colour_reg;
    logic [COLOUR_W-1:0] fill_colour_next;
    logic                init_reg;
    logic                init_next;
    logic [CNT_W-1:0]    i_reg;
    logic [CNT_W-1:0]    i_next;
    logic [CNT_W-1:0]    j_reg;
    logic [CNT_W-1:0]    j_next;
    entry_t              ent_reg;
    entry_t              ent_next;
    logic                b_valid_reg;
    logic                b_valid_next;
    logic [AW-1:0]       b_addr_reg;
    logic [AW-1:0]       b_addr_next;
    logic                b_hard_reg;
    logic                b_hard_next;
    logic                b_soft_reg;
    logic                b_soft_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [COLOUR_W-1:0] out_data_reg;
    logic [COLOUR_W-1:0] out_data_next;

    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [COLOUR_W-1:0]     mem_wdata;
    logic                    out_free;

    logic signed [POS_W-1:0] col;
    logic signed [POS_W-1:0] row;
    logic                    st_in_grid;
    logic [AW-1:0]           st_addr;
    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dz;
    logic signed [2*D_W-1:0] dx_w;
    logic signed [2*D_W-1:0] dz_w;
    logic [SQ_W-1:0]         dist_sq;
    logic                    dark;
    logic                    st_we;

    assign init_busy     = init_reg;
    assign result_valid  = out_valid_reg;
    assign result_colour = out_data_reg;
    assign out_free      = ~out_valid_reg | ~result_stall;

    always_comb
    begin
        col = ent_reg.col_base + $signed({{(POS_W - CNT_W){1'b0}}, i_reg});
        row = ent_reg.row_base + $signed({{(POS_W - CNT_W){1'b0}}, j_reg});
        st_in_grid = (col >= 0) && (col < $signed(POS_W'(GRID_WIDTH)))
                  && (row >= 0) && (row < $signed(POS_W'(GRID_HEIGHT)));
        st_addr = st_in_grid
                ? AW'(col[CW-1:0]) * AW'(GRID_HEIGHT) + AW'(row[RW-1:0])
                : '0;
        dx   = $signed({1'b0, i_reg}) - $signed(D_W'(SOFT_RADIUS));
        dz   = $signed({1'b0, j_reg}) - $signed(D_W'(SOFT_RADIUS));
        dx_w = (2 * D_W)'(dx);
        dz_w = (2 * D_W)'(dz);
        dist_sq = {1'b0, $unsigned(dx_w * dx_w)} + {1'b0, $unsigned(dz_w * dz_w)};
    end

    // Write stage of the stamp read-modify-write.
    always_comb
    begin
        dark  = ~rd_data_reg[7] & ~rd_data_reg[15] & ~rd_data_reg[23];
        st_we = b_valid_reg & (b_hard_reg | (b_soft_reg & dark));
    end

    always_comb
    begin
        state_next       = state_reg;
        fill_addr_next   = fill_addr_reg;
        fill_colour_next = fill_colour_reg;
        init_next        = init_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        ent_next         = ent_reg;
        b_valid_next     = 1'b0;
        b_addr_next      = b_addr_reg;
        b_hard_next      = 1'b0;
        b_soft_next      = 1'b0;
        out_valid_next   = out_valid_reg & result_stall;
        out_data_next    = out_data_reg;
        pop              = 1'b0;
        mem_re           = 1'b0;
        mem_raddr        = '0;
        mem_we           = st_we;
        mem_waddr        = b_addr_reg;
        mem_wdata        = b_hard_reg ? HARD_COLOUR : SOFT_COLOUR;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && !b_valid_reg)
                begin
                    pop              = 1'b1;
                    ent_next         = q_head;
                    fill_addr_next   = '0;
                    fill_colour_next = q_head.colour;
                    i_next           = '0;
                    j_next           = '0;
                    case (q_head.op)
                        OP_FILL:  state_next = BK_FILL;
                        OP_STAMP: state_next = BK_STAMP;
                        OP_READ:  state_next = BK_READ;
                        default:  state_next = BK_IDLE;
                    endcase
                end
            end
            BK_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_addr_reg;
                mem_wdata = fill_colour_reg;
                if (fill_addr_reg == AW'(CELLS - 1))
                begin
                    state_next = BK_IDLE;
                    init_next  = 1'b0;
                end
                else
                begin
                    fill_addr_next = fill_addr_reg + 1'b1;
                end
            end
            BK_STAMP:
            begin
                mem_re       = 1'b1;
                mem_raddr    = st_addr;
                b_valid_next = 1'b1;
                b_addr_next  = st_addr;
                b_hard_next  = st_in_grid && (dist_sq <= HARD_SQ);
                b_soft_next  = st_in_grid && (dist_sq > HARD_SQ) && (dist_sq <= SOFT_SQ);
                if (j_reg == LAST_STEP)
                begin
                    j_next = '0;
                    if (i_reg == LAST_STEP)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            BK_READ:
            begin
                if (out_free)
                begin
                    if (ent_reg.in_grid)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = ent_reg.addr[AW-1:0];
                        state_next = BK_READ_WAIT;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = ent_reg.colour;
                        state_next     = BK_IDLE;
                    end
                end
            end
            BK_READ_WAIT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = rd_data_reg;
                state_next     = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_FILL;
            fill_addr_reg   <= '0;
            fill_colour_reg <= WHITE_COLOUR;
            init_reg        <= 1'b1;
            i_reg           <= '0;
            j_reg           <= '0;
            b_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fill_addr_reg   <= fill_addr_next;
            fill_colour_reg <= fill_colour_next;
            init_reg        <= init_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            b_valid_reg     <= b_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        b_addr_reg   <= b_addr_next;
        b_hard_reg   <= b_hard_next;
        b_soft_reg   <= b_soft_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    a_wb_after_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> $past(state_reg) == BK_STAMP)
        else $error("write stage busy outside a stamp");
    a_init_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> state_reg == BK_FILL)
        else $error("clearing pass left before completion");
    a_pop_drained: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !b_valid_reg && state_reg == BK_IDLE)
        else $error("entry taken while write stage busy");
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_READ_WAIT |=> out_valid_reg)
        else $error("read data not loaded into result register");

endmodule
